// ===== rtl/cht_pkg.sv =====
package cht_pkg;
  localparam int NumBuckets     = 256;
  localparam int SlotsPerBucket = 8;
  localparam int ValueWidth     = 32;
  localparam int KeyWidth       = 31;
  localparam int CfgWidth       = 9;
  localparam int OutWidth       = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;
endpackage

// ===== rtl/cht_req_if.sv =====
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [30:0] key;
  logic [31:0] value;
  modport source (output valid, action, key, value, input ready);
  modport sink (input valid, action, key, value, output ready);
endinterface

// ===== rtl/cht_rsp_if.sv =====
interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] value_out;
  modport source (output valid, status, value_out, input ready);
  modport sink (input valid, status, value_out, output ready);
endinterface

// ===== rtl/cht_ram.sv =====
module cht_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/cht_front.sv =====
// accepts requests and computes the bucket by restoring division, one bit a cycle
module cht_front #(
  parameter int NumBuckets = cht_pkg::NumBuckets,
  parameter int BktW       = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [cht_pkg::CfgWidth-1:0] bucket_count_i,
  cht_req_if.sink                req,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output logic [1:0]             q_action_o,
  output logic [cht_pkg::KeyWidth-1:0] q_key_o,
  output logic [31:0]            q_value_o,
  output logic [BktW-1:0]        q_bucket_o
);
  localparam int KW = cht_pkg::KeyWidth;
  localparam int RW = 18;

  logic          busy_q, done_q;
  logic [4:0]    cnt_q;
  logic [RW-1:0] rem_q, div_q, trial;
  logic [KW-1:0] key_q;
  logic [1:0]    act_q;
  logic [31:0]   val_q;
  logic [16:0]   eff;

  always_comb begin
    eff = 17'(bucket_count_i);
    if (eff == 17'd0) eff = 17'd1;
    if (eff > 17'(NumBuckets)) eff = 17'(NumBuckets);
  end

  assign req.ready  = !busy_q && !done_q;
  assign trial      = {rem_q[RW-2:0], key_q[5'(KW-1) - cnt_q]};
  assign q_valid_o  = done_q;
  assign q_action_o = act_q;
  assign q_key_o    = key_q;
  assign q_value_o  = val_q;
  assign q_bucket_o = BktW'(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req.valid && req.ready) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(KW-1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (done_q && q_ready_i) begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      key_q <= req.key;
      act_q <= req.action;
      val_q <= req.value;
      rem_q <= '0;
      div_q <= RW'(eff);
    end else if (busy_q) begin
      rem_q <= (trial >= div_q) ? trial - div_q : trial;
    end
  end
endmodule

// ===== rtl/cht_back.sv =====
// walks the bucket slots, then commits any write and issues the result
// valid marks live beside the keys in the key memory and are cleared by a pass after reset
module cht_back #(
  parameter int NumBuckets     = cht_pkg::NumBuckets,
  parameter int SlotsPerBucket = cht_pkg::SlotsPerBucket,
  parameter int ValueWidth     = cht_pkg::ValueWidth,
  parameter int BktW           = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  logic [1:0]             q_action_i,
  input  logic [cht_pkg::KeyWidth-1:0] q_key_i,
  input  logic [31:0]            q_value_i,
  input  logic [BktW-1:0]        q_bucket_i,
  cht_rsp_if.source              rsp
);
  localparam int SW    = $clog2(SlotsPerBucket);
  localparam int Total = NumBuckets * SlotsPerBucket;
  localparam int AW    = $clog2(Total);
  localparam int KW    = cht_pkg::KeyWidth;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001, S_IDLE = 5'b00010, S_READ = 5'b00100, S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q;
  logic [SW:0]   slot_q, free_q, hit_q;
  logic          hit_f_q, free_f_q;
  logic [1:0]    act_q;
  logic [KW-1:0] key_q;
  logic [ValueWidth-1:0] val_q;
  logic [BktW-1:0] bkt_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] raddr, waddr;
  logic          we_kv, we_val;
  logic [KW:0]   wkv, rkv;
  logic [ValueWidth-1:0] rval;
  logic [ValueWidth-1:0] rval_hit_q;
  logic          rsp_v_q;
  logic [2:0]    st_q;
  logic [31:0]   vo_q;

  function automatic logic [AW-1:0] addr_of(logic [BktW-1:0] b, logic [SW:0] s);
    return AW'(b) * AW'(SlotsPerBucket) + AW'(s);
  endfunction

  assign q_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign raddr     = addr_of(bkt_q, slot_q);

  // write ports: clearing pass, insert/update and remove in the done step
  always_comb begin
    we_kv  = 1'b0;
    we_val = 1'b0;
    waddr  = addr_of(bkt_q, hit_f_q ? hit_q : free_q);
    wkv    = {1'b1, key_q};
    unique case (state_q)
      S_CLEAR: begin
        we_kv = 1'b1;
        waddr = clr_q;
        wkv   = '0;
      end
      S_DONE: begin
        if (act_q == cht_pkg::ACT_INSERT) begin
          we_val = hit_f_q || free_f_q;
          we_kv  = !hit_f_q && free_f_q;
        end else if (act_q == cht_pkg::ACT_REMOVE && hit_f_q) begin
          we_kv = 1'b1;
          wkv   = {1'b0, key_q};
        end
      end
      default: ;
    endcase
  end

  // entry is {valid, key}
  cht_ram #(.Width(KW+1), .Depth(Total)) u_key (
    .clk_i, .we_i(we_kv), .waddr_i(waddr), .wdata_i(wkv),
    .raddr_i(raddr), .rdata_o(rkv));
  cht_ram #(.Width(ValueWidth), .Depth(Total)) u_val (
    .clk_i, .we_i(we_val), .waddr_i(waddr), .wdata_i(val_q),
    .raddr_i(raddr), .rdata_o(rval));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Total - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (q_valid_i && q_ready_o) state_q <= S_READ;
        S_READ: state_q <= S_CHECK;
        S_CHECK: begin
          if (hit_f_q || slot_q == (SW+1)'(SlotsPerBucket)) state_q <= S_DONE;
          else state_q <= S_CHECK;
        end
        S_DONE: begin
          state_q <= S_IDLE;
          rsp_v_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (q_valid_i && q_ready_o) begin
        act_q <= q_action_i; key_q <= q_key_i;
        val_q <= ValueWidth'(q_value_i); bkt_q <= q_bucket_i;
        slot_q <= '0; hit_f_q <= 1'b0; free_f_q <= 1'b0;
      end
      S_READ: slot_q <= slot_q + 1'b1;
      S_CHECK: if (!hit_f_q) begin
        // rdata belongs to slot_q-1
        if (rkv[KW] && rkv[KW-1:0] == key_q) begin
          hit_f_q <= 1'b1; hit_q <= slot_q - 1'b1;
        end else if (!rkv[KW] && !free_f_q) begin
          free_f_q <= 1'b1; free_q <= slot_q - 1'b1;
        end
        if (slot_q != (SW+1)'(SlotsPerBucket)) slot_q <= slot_q + 1'b1;
      end
      S_DONE: begin
        vo_q <= '0;
        st_q <= cht_pkg::ST_NOT_FOUND;
        unique case (act_q)
          cht_pkg::ACT_INSERT: st_q <= hit_f_q ? cht_pkg::ST_UPDATED :
                                 free_f_q ? cht_pkg::ST_INSERTED : cht_pkg::ST_FULL;
          cht_pkg::ACT_SEARCH: if (hit_f_q) begin
            st_q <= cht_pkg::ST_FOUND; vo_q <= 32'(rval_hit_q);
          end
          cht_pkg::ACT_REMOVE: if (hit_f_q) st_q <= cht_pkg::ST_REMOVED;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // payload of the matching slot, captured during the walk
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK && !hit_f_q) rval_hit_q <= rval;
  end

  assign rsp.valid     = rsp_v_q;
  assign rsp.status    = st_q;
  assign rsp.value_out = vo_q;
endmodule

// ===== rtl/chained_hash_table.sv =====
// Hash table engine with modulo bucket hashing and SLOTS_PER_BUCKET slots per
// bucket. One request is in flight at a time in each of two parts: the front
// takes a transfer and finds key mod bucket_count (clamped to 1..NUM_BUCKETS)
// by a 31-step restoring division; the back walks the bucket through the slot
// memories, one slot a cycle with early stop on a match. A one-entry handoff
// between them lets the next division overlap the current walk. Valid marks
// are kept with the keys in the key memory; after reset the back clears them
// in a pass over all NUM_BUCKETS*SLOTS_PER_BUCKET entries (2048 at the
// defaults) before it takes its first request.
module chained_hash_table #(
  parameter int NumBuckets     = cht_pkg::NumBuckets,
  parameter int SlotsPerBucket = cht_pkg::SlotsPerBucket,
  parameter int ValueWidth     = cht_pkg::ValueWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  cht_req_if.sink    req,
  cht_rsp_if.source  rsp
);
  localparam int BktW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;

  logic [8:0] bucket_count_q;
  logic q_valid, q_ready;
  logic [1:0] q_action;
  logic [cht_pkg::KeyWidth-1:0] q_key;
  logic [31:0] q_value;
  logic [BktW-1:0] q_bucket;

  // bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bucket_count_q <= 9'd256;
    else if (cfg_we_i) bucket_count_q <= cfg_wdata_i;
  end

  cht_front #(.NumBuckets(NumBuckets), .BktW(BktW)) u_front (
    .clk_i, .rst_ni, .bucket_count_i(bucket_count_q), .req,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_action_o(q_action),
    .q_key_o(q_key), .q_value_o(q_value), .q_bucket_o(q_bucket));

  cht_back #(.NumBuckets(NumBuckets), .SlotsPerBucket(SlotsPerBucket),
    .ValueWidth(ValueWidth), .BktW(BktW)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_action_i(q_action), .q_key_i(q_key), .q_value_i(q_value),
    .q_bucket_i(q_bucket), .rsp);
endmodule

// ===== rtl/cht_checker.sv =====
module cht_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [2:0] rsp_status,
  input logic [31:0] rsp_value_out
);
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_status <= cht_pkg::ST_FULL) else $error("bad status");
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != cht_pkg::ST_FOUND |-> rsp_value_out == 32'd0)
    else $error("value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)) else $error("hold");
endmodule

bind chained_hash_table cht_checker u_chk (
  .clk_i, .rst_ni, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_value_out(rsp.value_out));
